/* src/mrfc_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the Modbus response checker.
package mrfc_pkg;

  localparam int MAX_FRAME = 256;
  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int CMP_W = ((CNT_W > 9) ? CNT_W : 9) + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] FUNC_READ = 8'h03;
  localparam int FUNC_EXC_BIT = 7;
  localparam int MIN_FRAME = 5;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_CRC_BAD      = 3'd2,
    ST_EXCEPTION    = 3'd3,
    ST_BAD_FUNC     = 3'd4,
    ST_LEN_MISMATCH = 3'd5,
    ST_ODD_COUNT    = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic        is_status;
    logic [6:0]  reg_index;
    logic [15:0] reg_value;
    logic [7:0]  slave_addr;
    logic [7:0]  func_code;
    status_t     status;
    logic [7:0]  exc_code;
    logic        run_end;
  } out_t;

  // One accepted byte's worth of results: an optional word and an optional status.
  typedef struct packed {
    logic        word_valid;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic        stat_valid;
    logic [7:0]  slave_addr;
    logic [7:0]  func_code;
    status_t     status;
    logic [7:0]  exc_code;
  } rec_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* src/mrfc_front.sv */
// Front end: frame byte tracking, CRC and classification into result records.
module mrfc_front (
  input  logic           clk,
  input  logic           rst,
  input  mrfc_pkg::in_t  item,
  input  logic           accept,
  output mrfc_pkg::rec_t rec
);

  logic [15:0]                crc_acc;
  logic [7:0]                 dly0;
  logic [7:0]                 dly1;
  logic [mrfc_pkg::CNT_W-1:0] byte_counter;
  logic [7:0]                 slave_hold;
  logic [7:0]                 func_hold;
  logic [7:0]                 count_hold;
  logic [7:0]                 high_byte_hold;

  logic [15:0]                crc_next;
  logic [7:0]                 slave_next;
  logic [7:0]                 func_next;
  logic [7:0]                 count_next;
  logic [7:0]                 high_next;
  logic [mrfc_pkg::CNT_W-1:0] counter_next;
  logic [mrfc_pkg::CNT_W-1:0] k;
  logic [mrfc_pkg::CMP_W-1:0] pos1;
  logic [15:0]                given;
  logic                       in_range;
  logic                       word_hit;
  mrfc_pkg::status_t          code;

  always_comb begin
    in_range = byte_counter < mrfc_pkg::CNT_W'(mrfc_pkg::MAX_FRAME);

    slave_next = slave_hold;
    func_next  = func_hold;
    count_next = count_hold;
    if (in_range) begin
      if (byte_counter == mrfc_pkg::CNT_W'(0)) slave_next = item.data_byte;
      else if (byte_counter == mrfc_pkg::CNT_W'(1)) func_next = item.data_byte;
      else if (byte_counter == mrfc_pkg::CNT_W'(2)) count_next = item.data_byte;
    end

    // the byte leaving the two-stage delay is payload, never the trailing CRC
    crc_next = (byte_counter >= mrfc_pkg::CNT_W'(2)) ? mrfc_pkg::crc16_byte(crc_acc, dly1)
                                                     : crc_acc;

    k = byte_counter - mrfc_pkg::CNT_W'(mrfc_pkg::MIN_FRAME);
    word_hit = in_range && (byte_counter >= mrfc_pkg::CNT_W'(mrfc_pkg::MIN_FRAME)) &&
               (func_hold == mrfc_pkg::FUNC_READ) &&
               (mrfc_pkg::CMP_W'(k) < mrfc_pkg::CMP_W'(count_hold));
    high_next = (word_hit && !k[0]) ? dly1 : high_byte_hold;

    counter_next = in_range ? byte_counter + mrfc_pkg::CNT_W'(1) : byte_counter;

    pos1  = mrfc_pkg::CMP_W'(byte_counter) + mrfc_pkg::CMP_W'(1);
    given = {item.data_byte, dly0};

    if (in_range && (pos1 < mrfc_pkg::CMP_W'(mrfc_pkg::MIN_FRAME))) begin
      code = mrfc_pkg::ST_SHORT;
    end else if (given != crc_next) begin
      code = mrfc_pkg::ST_CRC_BAD;
    end else if (func_next[mrfc_pkg::FUNC_EXC_BIT]) begin
      code = mrfc_pkg::ST_EXCEPTION;
    end else if (func_next != mrfc_pkg::FUNC_READ) begin
      code = mrfc_pkg::ST_BAD_FUNC;
    end else if (!in_range ||
                 (pos1 != mrfc_pkg::CMP_W'(count_next) + mrfc_pkg::CMP_W'(mrfc_pkg::MIN_FRAME)))
    begin
      code = mrfc_pkg::ST_LEN_MISMATCH;
    end else if (count_next[0]) begin
      code = mrfc_pkg::ST_ODD_COUNT;
    end else begin
      code = mrfc_pkg::ST_OK;
    end

    rec.word_valid = word_hit && k[0];
    rec.word_index = 7'(k >> 1);
    rec.word_value = {high_byte_hold, dly1};
    rec.stat_valid = item.frame_end;
    rec.status     = code;
    rec.slave_addr = (code == mrfc_pkg::ST_SHORT) ? 8'h00 : slave_next;
    rec.func_code  = (code == mrfc_pkg::ST_SHORT) ? 8'h00 : func_next;
    rec.exc_code   = (code == mrfc_pkg::ST_EXCEPTION) ? count_next : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && item.frame_end)) begin
      crc_acc        <= mrfc_pkg::CRC_INIT;
      dly0           <= 8'h00;
      dly1           <= 8'h00;
      byte_counter   <= '0;
      slave_hold     <= 8'h00;
      func_hold      <= 8'h00;
      count_hold     <= 8'h00;
      high_byte_hold <= 8'h00;
    end else if (accept) begin
      crc_acc        <= crc_next;
      dly1           <= dly0;
      dly0           <= item.data_byte;
      byte_counter   <= counter_next;
      slave_hold     <= slave_next;
      func_hold      <= func_next;
      count_hold     <= count_next;
      high_byte_hold <= high_next;
    end
  end

endmodule

/* src/mrfc_queue.sv */
// Short record queue between the classifier and the result sequencer.
module mrfc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrfc_pkg::rec_t wr,
  input  logic           pop,
  output mrfc_pkg::rec_t head,
  output logic           head_valid,
  output logic           full
);

  mrfc_pkg::rec_t              entries [mrfc_pkg::QUEUE_DEPTH];
  logic [mrfc_pkg::QPTR_W-1:0] wr_ptr;
  logic [mrfc_pkg::QPTR_W-1:0] rd_ptr;
  logic [mrfc_pkg::QPTR_W:0]   count;

  assign head       = entries[rd_ptr];
  assign head_valid = count != '0;
  assign full       = count == (mrfc_pkg::QPTR_W+1)'(mrfc_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + mrfc_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + mrfc_pkg::QPTR_W'(1);
      if (push && !pop) count <= count + (mrfc_pkg::QPTR_W+1)'(1);
      else if (pop && !push) count <= count - (mrfc_pkg::QPTR_W+1)'(1);
    end
  end

endmodule

/* src/mrfc_back.sv */
// Back end: splits each record into its word and status results, in order.
module mrfc_back (
  input  logic           clk,
  input  logic           rst,
  input  mrfc_pkg::rec_t head,
  input  logic           head_valid,
  input  logic           pop,
  output logic           head_done,
  output logic           empty,
  output mrfc_pkg::out_t result
);

  logic phase;  // word of the head record already transferred
  logic show_word;

  assign show_word = head.word_valid && !phase;
  assign empty     = !head_valid;
  assign head_done = pop && head_valid && !(show_word && head.stat_valid);

  always_comb begin
    result = '0;
    if (show_word) begin
      result.reg_index = head.word_index;
      result.reg_value = head.word_value;
      result.run_end   = !head.stat_valid;
    end else begin
      result.is_status  = 1'b1;
      result.slave_addr = head.slave_addr;
      result.func_code  = head.func_code;
      result.status     = head.status;
      result.exc_code   = head.exc_code;
      result.run_end    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (pop && head_valid) begin
      phase <= show_word && head.stat_valid;
    end
  end

endmodule

/* src/modbus_response_frame_checker.sv */
// Top level of the Modbus RTU response frame checker.
// Input channel: push/full carry raw response bytes (data_byte, frame_end) in
// frame order; a byte transfers when push is high and full is low.
// Result channel: empty/pop; the oldest result sits on result while empty is
// low and transfers when pop is high. Function 03 responses give one
// register word per data byte pair (tentative until the status), and the
// byte with frame_end gives the frame status as the last result of that byte.
// Each byte's results are written to the queue and reach result in order, behind any earlier results.
// Throughput: one byte per cycle while full is low; a final byte that also completes a word
// gives two results, the word and then the status. A four-record queue between the classifier and
// the result sequencer absorbs that and short result stalls.
// When pop stays low the queue fills and full rises; nothing is dropped.
// Reset (rst, synchronous) empties the queue and starts a new frame.
module modbus_response_frame_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  mrfc_pkg::in_t  item,
  output logic           empty,
  input  logic           pop,
  output mrfc_pkg::out_t result
);

  mrfc_pkg::rec_t rec;
  mrfc_pkg::rec_t head;
  logic           accept;
  logic           q_push;
  logic           head_valid;
  logic           head_done;

  assign accept = push && !full;
  assign q_push = accept && (rec.word_valid || rec.stat_valid);

  mrfc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .accept (accept),
    .rec    (rec)
  );

  mrfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .wr         (rec),
    .pop        (head_done),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  mrfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .head_done  (head_done),
    .empty      (empty),
    .result     (result)
  );

`ifndef NO_ASSERTIONS
  // a word followed by a status from the same byte hands over to that status
  a_word_then_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.is_status && !result.run_end) |=>
      (!empty && result.is_status))
    else $error("status did not follow its word");

  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.is_status) |-> result.run_end)
    else $error("status result without run_end");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queue not cleared by reset");
`endif

endmodule

/* tb/sv/tb_modbus_response_frame_checker.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Modbus RTU response frame checker.
module tb_modbus_response_frame_checker;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TARGET_BYTES = 650;
  localparam int DRAIN_CYCLES = 10;

  typedef logic [7:0] byte_q_t[$];

  // Frame-level predictor plus the queue of results it still awaits.
  class frame_scoreboard;
    logic [15:0] crc;
    logic [7:0] dly0, dly1;
    int unsigned cnt;
    logic [7:0] slave, func, bcount, hi;
    mrfc_pkg::out_t awaited[$];
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      crc = mrfc_pkg::CRC_INIT;
      dly0 = '0;
      dly1 = '0;
      cnt = 0;
      slave = '0;
      func = '0;
      bcount = '0;
      hi = '0;
    endfunction

    // bitwise form: feed data bits LSB first into the reflected register
    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
      logic [15:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
        if (r[0] ^ d[i]) r = (r >> 1) ^ mrfc_pkg::CRC_POLY;
        else r = r >> 1;
      end
      return r;
    endfunction

    function void note_byte(mrfc_pkg::in_t it);
      logic [7:0] b, ob, prev;
      bit last, in_range;
      int unsigned pos, k;
      mrfc_pkg::out_t r;
      mrfc_pkg::status_t code;
      logic [7:0] exc;
      b = it.data_byte;
      last = it.frame_end;
      pos = cnt;
      in_range = pos < mrfc_pkg::MAX_FRAME;
      prev = dly0;
      if (in_range) begin
        case (pos)
          0: slave = b;
          1: func = b;
          2: bcount = b;
          default: ;
        endcase
      end
      // CRC and payload only see bytes leaving the two-byte delay
      if (pos >= 2) begin
        ob = dly1;
        crc = crc_step(crc, ob);
        if (in_range && pos >= 5 && func == mrfc_pkg::FUNC_READ) begin
          k = pos - 5;
          if (k < bcount) begin
            if (k % 2 == 0) begin
              hi = ob;
            end else begin
              r = '0;
              r.reg_index = 7'(k / 2);
              r.reg_value = {hi, ob};
              r.run_end = !last;
              awaited.insert(awaited.size(), r);
            end
          end
        end
      end
      dly1 = dly0;
      dly0 = b;
      if (cnt < mrfc_pkg::MAX_FRAME) cnt++;
      if (last) begin
        exc = '0;
        if (in_range && pos + 1 < mrfc_pkg::MIN_FRAME) code = mrfc_pkg::ST_SHORT;
        else if ({b, prev} != crc) code = mrfc_pkg::ST_CRC_BAD;
        else if (func[mrfc_pkg::FUNC_EXC_BIT]) begin
          code = mrfc_pkg::ST_EXCEPTION;
          exc = bcount;
        end
        else if (func != mrfc_pkg::FUNC_READ) code = mrfc_pkg::ST_BAD_FUNC;
        else if (!in_range || pos + 1 != bcount + mrfc_pkg::MIN_FRAME)
          code = mrfc_pkg::ST_LEN_MISMATCH;
        else if (bcount[0]) code = mrfc_pkg::ST_ODD_COUNT;
        else code = mrfc_pkg::ST_OK;
        r = '0;
        r.is_status = 1'b1;
        r.status = code;
        r.exc_code = exc;
        r.run_end = 1'b1;
        if (code != mrfc_pkg::ST_SHORT) begin
          r.slave_addr = slave;
          r.func_code = func;
        end
        awaited.insert(awaited.size(), r);
        clear();
      end
    endfunction

    function void cmp(string name, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        $error("%s: expected %0h, got %0h", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(mrfc_pkg::out_t got);
      mrfc_pkg::out_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result transfer: %h", got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      cmp("is_status", want.is_status, got.is_status);
      cmp("reg_index", want.reg_index, got.reg_index);
      cmp("reg_value", want.reg_value, got.reg_value);
      cmp("slave_addr", want.slave_addr, got.slave_addr);
      cmp("func_code", want.func_code, got.func_code);
      cmp("status", want.status, got.status);
      cmp("exc_code", want.exc_code, got.exc_code);
      cmp("run_end", want.run_end, got.run_end);
    endfunction
  endclass

  bit clk;
  logic rst, push, pop, full, empty;
  mrfc_pkg::in_t item;
  mrfc_pkg::out_t result;
  bit calm;
  int idle_cycles = 0;
  int bytes_sent = 0;
  frame_scoreboard sb;

  modbus_response_frame_checker dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 9);
  endfunction

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop <= !idle_roll();
    end
  end

  // transfer monitor, checker and watchdog
  always @(posedge clk) begin
    if (rst !== 1'b1) begin
      if (pop && !empty) sb.check_result(result);
      if (push && !full) sb.note_byte(item);
      if ((pop && !empty) || (push && !full)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_modbus_response_frame_checker NOT OK");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, bit last);
    @(negedge clk);
    while (idle_roll()) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= mrfc_pkg::in_t'{data_byte: b, frame_end: last};
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_frame(byte_q_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  function automatic byte_q_t rand_bytes(int n);
    byte_q_t q;
    repeat (n) q.insert(q.size(), 8'($urandom_range(255)));
    return q;
  endfunction

  function automatic byte_q_t with_crc(byte_q_t f);
    logic [15:0] c;
    c = mrfc_pkg::CRC_INIT;
    foreach (f[i]) c = frame_scoreboard::crc_step(c, f[i]);
    f.insert(f.size(), c[7:0]);
    f.insert(f.size(), c[15:8]);
    return f;
  endfunction

  function automatic byte_q_t read_resp(logic [7:0] sa, logic [7:0] fc, logic [7:0] count,
                                        int ndata);
    byte_q_t q;
    q = rand_bytes(ndata);
    q.push_front(count);
    q.push_front(fc);
    q.push_front(sa);
    return with_crc(q);
  endfunction

  function automatic logic [7:0] other_func();
    logic [7:0] f;
    f = 8'($urandom_range(127));
    if (f == mrfc_pkg::FUNC_READ) f = 8'h04;
    return f;
  endfunction

  function automatic byte_q_t corrupt(byte_q_t f);
    f[$urandom_range(f.size() - 1)] ^= 8'(1 << $urandom_range(7));
    return f;
  endfunction

  function automatic byte_q_t random_frame();
    int pick, n, c;
    pick = $urandom_range(99);
    n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    if (pick < 50) begin
      n = n & ~1;
      return read_resp(8'($urandom_range(255)), mrfc_pkg::FUNC_READ, 8'(n), n);
    end else if (pick < 58) begin
      return rand_bytes($urandom_range(1, 4));
    end else if (pick < 66) begin
      return corrupt(read_resp(8'($urandom_range(255)), mrfc_pkg::FUNC_READ, 8'(n & ~1),
                               n & ~1));
    end else if (pick < 72) begin
      return read_resp(8'($urandom_range(255)), 8'($urandom_range(255)) | 8'h80,
                       8'($urandom_range(255)), 0);
    end else if (pick < 78) begin
      return read_resp(8'($urandom_range(255)), other_func(), 8'(n), $urandom_range(0, 6));
    end else if (pick < 86) begin
      c = $urandom_range(255);
      n = $urandom_range(0, 16);
      if (c == n) c = n + 1;
      return read_resp(8'($urandom_range(255)), mrfc_pkg::FUNC_READ, 8'(c), n);
    end else if (pick < 92) begin
      n = n | 1;
      return read_resp(8'($urandom_range(255)), mrfc_pkg::FUNC_READ, 8'(n), n);
    end else begin
      return rand_bytes($urandom_range(5, 20));
    end
  endfunction

  initial begin
    int frame_no;
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    calm = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: short frames, minimal and typical responses, CRC error, exception and bad function
    send_frame('{8'hFF});
    send_frame('{8'h00, 8'h03});
    send_frame('{8'hFF, 8'h03, 8'hFF});
    send_frame('{8'h00, 8'h83, 8'h02, 8'hFF});
    send_frame(read_resp(8'hFF, mrfc_pkg::FUNC_READ, 8'd0, 0));
    send_frame(read_resp(8'h00, mrfc_pkg::FUNC_READ, 8'd2, 2));
    send_frame(read_resp(8'h11, 8'h83, 8'h02, 0));
    send_frame(read_resp(8'h11, 8'h00, 8'h00, 0));
    send_frame(corrupt(read_resp(8'h11, mrfc_pkg::FUNC_READ, 8'd0, 0)));

    // random frames; one overlong frame early on
    frame_no = 0;
    while (bytes_sent < TARGET_BYTES) begin
      calm = frame_no >= 10 && frame_no < 22;
      if (frame_no == 5) begin
        send_frame(read_resp(8'($urandom_range(255)), mrfc_pkg::FUNC_READ, 8'd254, 254));
      end
      send_frame(random_frame());
      frame_no++;
    end
    calm = 1'b0;
    @(negedge clk);
    push <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb_modbus_response_frame_checker OK");
    end else begin
      $display("tb_modbus_response_frame_checker NOT OK");
    end
    $finish;
  end

endmodule
